// ===== rtl/lpc_pkg.sv =====
// lpc_pkg: shared constants and types of the lru page cache policy block
// no dependencies; used by lru_page_cache_policy and its bench
package lpc_pkg;

   // default geometry
   localparam int ENTRIES_DEF  = 16;
   localparam int REF_BITS_DEF = 8;

   // fixed field widths
   localparam int INODE_W  = 16;
   localparam int OFFSET_W = 32;
   localparam int SLOT_W   = 4;
   localparam int CAP_W    = 5;
   localparam int TOTAL_W  = 32;

   // most writeback words one sync gives
   localparam int MAX_OUT   = 16;
   localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

   // capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // operation codes
   typedef enum logic [2:0] {
      KIND_LOOKUP = 3'd0,
      KIND_FIND   = 3'd1,
      KIND_DIRTY  = 3'd2,
      KIND_PUT    = 3'd3,
      KIND_INVAL  = 3'd4,
      KIND_SYNC   = 3'd5
   } kind_type;

endpackage

// ===== rtl/lpc_ram.sv =====
// lpc_ram: generic single write port, single read port ram with registered read
// no dependencies
module lpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read, data holds while not reading
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lpc_lru.sv =====
// lpc_lru: recency rank table, move-to-front and slot-of-rank lookup
// depends on lpc_pkg only through the parent's parameters
module lpc_lru #(
   parameter int ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tf_en,
   input  logic [$clog2(ENTRIES)-1:0] tf_slot,
   input  logic [$clog2(ENTRIES)-1:0] find_rank,
   output logic [$clog2(ENTRIES)-1:0] find_slot
);

   localparam int IDX_W = $clog2(ENTRIES);

   logic [IDX_W-1:0] rank_ff [ENTRIES];
   logic [IDX_W-1:0] tf_rank;

   assign tf_rank = rank_ff[tf_slot];

   // slot holding the asked rank, ranks form a permutation
   always_comb begin
      find_slot = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (rank_ff[i] == find_rank) begin
            find_slot = IDX_W'(i);
         end
      end
   end

   // move one slot to the front, everything more recent ages by one
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= IDX_W'(i);
         end
      end else if (tf_en) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (IDX_W'(i) == tf_slot) begin
               rank_ff[i] <= '0;
            end else if (rank_ff[i] < tf_rank) begin
               rank_ff[i] <= rank_ff[i] + IDX_W'(1);
            end
         end
      end
   end

endmodule

// ===== rtl/lru_page_cache_policy.sv =====
// lru_page_cache_policy: fully associative page table with lru order and pinning
// one request at a time; lookup, put, mark dirty, invalidate and sync scan the keys slot
// by slot, each slot read from the key ram and then compared.
// a create with eviction adds a victim search from the lru tail.
// sync words wait on rsp_stall; the key ram read port sets the pace throughout.
// reset: synchronous, all slots empty, lru order by slot index, capacity 16, totals 0
module lru_page_cache_policy #(
   parameter int ENTRIES  = lpc_pkg::ENTRIES_DEF,
   parameter int REF_BITS = lpc_pkg::REF_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [lpc_pkg::CAP_W-1:0]     csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_kind,
   input  logic [lpc_pkg::INODE_W-1:0]   req_inode_id,
   input  logic [lpc_pkg::OFFSET_W-1:0]  req_page_offset,
   input  logic                          req_every_inode,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [lpc_pkg::SLOT_W-1:0]    rsp_slot,
   output logic                          rsp_evicted,
   output logic                          rsp_no_victim,
   output logic                          rsp_wb_valid,
   output logic [lpc_pkg::INODE_W-1:0]   rsp_wb_inode,
   output logic [lpc_pkg::OFFSET_W-1:0]  rsp_wb_offset,
   output logic                          rsp_last,
   output logic [lpc_pkg::TOTAL_W-1:0]   rsp_hit_total,
   output logic [lpc_pkg::TOTAL_W-1:0]   rsp_miss_total
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int RAM_W = lpc_pkg::INODE_W + lpc_pkg::OFFSET_W + REF_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_EV, S_ACT, S_MISS, S_VFIND, S_VCHK, S_ALLOC, S_EMIT, S_SFIN
   } state_type;

   state_type                     state_ff;
   lpc_pkg::kind_type             kind_ff;
   logic [lpc_pkg::INODE_W-1:0]   ino_ff;
   logic [lpc_pkg::OFFSET_W-1:0]  off_ff;
   logic                          all_ff;
   logic [IDX_W-1:0]              idx_ff;
   logic [ENTRIES-1:0]            valid_ff;
   logic [ENTRIES-1:0]            dirty_ff;
   logic [CNT_W-1:0]              resident_ff;
   logic [lpc_pkg::CAP_W-1:0]     cap_ff;
   logic [lpc_pkg::TOTAL_W-1:0]   hit_cnt_ff;
   logic [lpc_pkg::TOTAL_W-1:0]   miss_cnt_ff;
   logic [IDX_W-1:0]              pos_ff;
   logic [CNT_W-1:0]              step_ff;
   logic [IDX_W-1:0]              vslot_ff;
   logic [lpc_pkg::OUT_CNT_W-1:0] nout_ff;
   logic                          pend_ff;
   logic [lpc_pkg::INODE_W-1:0]   pend_ino_ff;
   logic [lpc_pkg::OFFSET_W-1:0]  pend_off_ff;

   // staged result word
   logic                          res_hit_ff;
   logic [lpc_pkg::SLOT_W-1:0]    res_slot_ff;
   logic                          res_ev_ff;
   logic                          res_nv_ff;
   logic                          res_wbv_ff;
   logic [lpc_pkg::INODE_W-1:0]   res_wbi_ff;
   logic [lpc_pkg::OFFSET_W-1:0]  res_wbo_ff;

   // output register
   logic                          rsp_valid_ff;
   logic                          rsp_hit_ff;
   logic [lpc_pkg::SLOT_W-1:0]    rsp_slot_ff;
   logic                          rsp_ev_ff;
   logic                          rsp_nv_ff;
   logic                          rsp_wbv_ff;
   logic [lpc_pkg::INODE_W-1:0]   rsp_wbi_ff;
   logic [lpc_pkg::OFFSET_W-1:0]  rsp_wbo_ff;
   logic                          rsp_last_ff;
   logic [lpc_pkg::TOTAL_W-1:0]   rsp_hit_tot_ff;
   logic [lpc_pkg::TOTAL_W-1:0]   rsp_miss_tot_ff;

   logic                          rd_en;
   logic [IDX_W-1:0]              rd_addr;
   logic [RAM_W-1:0]              rd_data;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic [RAM_W-1:0]              wr_data;
   logic                          tf_en;
   logic [IDX_W-1:0]              tf_slot;
   logic [IDX_W-1:0]              find_slot;
   logic [lpc_pkg::INODE_W-1:0]   rd_ino;
   logic [lpc_pkg::OFFSET_W-1:0]  rd_off;
   logic [REF_BITS-1:0]           rd_refs;
   logic [REF_BITS-1:0]           refs_dec;
   logic                          free_any;
   logic [IDX_W-1:0]              free_slot;
   logic                          out_free;
   logic                          rsp_load;
   logic                          idx_last;
   logic                          evict_due;
   logic                          key_hit;
   logic                          ino_hit;
   logic                          sync_hit;

   // key store: {inode, offset, refs} per slot
   lpc_ram #(
      .WIDTH (RAM_W),
      .DEPTH (ENTRIES)
   ) u_keys (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // recency order
   lpc_lru #(
      .ENTRIES (ENTRIES)
   ) u_lru (
      .clock     (clock),
      .reset     (reset),
      .tf_en     (tf_en),
      .tf_slot   (tf_slot),
      .find_rank (pos_ff),
      .find_slot (find_slot)
   );

   // fields of the slot just read
   assign rd_ino   = rd_data[RAM_W-1 -: lpc_pkg::INODE_W];
   assign rd_off   = rd_data[REF_BITS +: lpc_pkg::OFFSET_W];
   assign rd_refs  = rd_data[REF_BITS-1:0];
   assign refs_dec = rd_refs - REF_BITS'(1);

   // shared compare against the scanned slot
   assign ino_hit  = valid_ff[idx_ff] && (rd_ino == ino_ff);
   assign key_hit  = ino_hit && (rd_off == off_ff);
   assign sync_hit = valid_ff[idx_ff] && dirty_ff[idx_ff] && (all_ff || rd_ino == ino_ff);
   assign idx_last = (idx_ff == IDX_W'(ENTRIES - 1));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // output register takes a new word this cycle
   assign rsp_load = out_free && ((state_ff == S_EMIT) || (state_ff == S_SFIN) ||
                                  (state_ff == S_EV && kind_ff == lpc_pkg::KIND_SYNC &&
                                   sync_hit && pend_ff));

   assign evict_due = ((32'(resident_ff) >= 32'(cap_ff)) ||
                       (32'(resident_ff) >= 32'(ENTRIES))) && (resident_ff != '0);

   // lowest empty slot
   always_comb begin
      free_any  = 1'b0;
      free_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any  = 1'b1;
            free_slot = IDX_W'(i);
         end
      end
   end

   // ram and rank table controls
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_ff;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = {ino_ff, off_ff, REF_BITS'(1)};
      tf_en   = 1'b0;
      tf_slot = idx_ff;
      case (state_ff)
         S_RD: begin
            rd_en = 1'b1;
         end
         S_ACT: begin
            if (kind_ff == lpc_pkg::KIND_PUT) begin
               wr_en   = 1'b1;
               wr_data = {rd_ino, rd_off, refs_dec};
            end else begin
               tf_en = 1'b1;
            end
         end
         S_VFIND: begin
            rd_en   = valid_ff[find_slot];
            rd_addr = find_slot;
         end
         S_VCHK: begin
            tf_en   = (rd_refs > REF_BITS'(1));
            tf_slot = vslot_ff;
         end
         S_ALLOC: begin
            wr_en   = free_any;
            wr_addr = free_slot;
            tf_en   = free_any;
            tf_slot = free_slot;
         end
         default: begin
         end
      endcase
   end

   // sequencer, table state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         resident_ff  <= '0;
         cap_ff       <= lpc_pkg::CAP_RESET;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         // output word valid: set on load, cleared once taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff     <= lpc_pkg::kind_type'(req_kind);
                  ino_ff      <= req_inode_id;
                  off_ff      <= req_page_offset;
                  all_ff      <= req_every_inode;
                  idx_ff      <= '0;
                  nout_ff     <= '0;
                  pend_ff     <= 1'b0;
                  res_hit_ff  <= 1'b0;
                  res_slot_ff <= '0;
                  res_ev_ff   <= 1'b0;
                  res_nv_ff   <= 1'b0;
                  res_wbv_ff  <= 1'b0;
                  res_wbi_ff  <= '0;
                  res_wbo_ff  <= '0;
                  case (req_kind) inside
                     [lpc_pkg::KIND_LOOKUP:lpc_pkg::KIND_SYNC]: state_ff <= S_RD;
                     default:                                   state_ff <= S_EMIT;
                  endcase
               end
            end
            S_RD: begin
               state_ff <= S_EV;
            end
            S_EV: begin
               case (kind_ff)
                  lpc_pkg::KIND_INVAL: begin
                     if (ino_hit) begin
                        valid_ff[idx_ff] <= 1'b0;
                        dirty_ff[idx_ff] <= 1'b0;
                        if (resident_ff != '0) begin
                           resident_ff <= resident_ff - CNT_W'(1);
                        end
                     end
                     if (idx_last) begin
                        state_ff <= S_EMIT;
                     end else begin
                        idx_ff   <= idx_ff + IDX_W'(1);
                        state_ff <= S_RD;
                     end
                  end
                  lpc_pkg::KIND_SYNC: begin
                     if (sync_hit) begin
                        if (!pend_ff || out_free) begin
                           // push out the word held back, keep this one pending
                           if (pend_ff) begin
                              rsp_hit_ff      <= 1'b0;
                              rsp_slot_ff     <= '0;
                              rsp_ev_ff       <= 1'b0;
                              rsp_nv_ff       <= 1'b0;
                              rsp_wbv_ff      <= 1'b1;
                              rsp_wbi_ff      <= pend_ino_ff;
                              rsp_wbo_ff      <= pend_off_ff;
                              rsp_last_ff     <= 1'b0;
                              rsp_hit_tot_ff  <= hit_cnt_ff;
                              rsp_miss_tot_ff <= miss_cnt_ff;
                           end
                           pend_ff          <= 1'b1;
                           pend_ino_ff      <= rd_ino;
                           pend_off_ff      <= rd_off;
                           dirty_ff[idx_ff] <= 1'b0;
                           nout_ff          <= nout_ff + lpc_pkg::OUT_CNT_W'(1);
                           if (idx_last ||
                               nout_ff == lpc_pkg::OUT_CNT_W'(lpc_pkg::MAX_OUT - 1)) begin
                              state_ff <= S_SFIN;
                           end else begin
                              idx_ff   <= idx_ff + IDX_W'(1);
                              state_ff <= S_RD;
                           end
                        end
                     end else if (idx_last) begin
                        state_ff <= S_SFIN;
                     end else begin
                        idx_ff   <= idx_ff + IDX_W'(1);
                        state_ff <= S_RD;
                     end
                  end
                  default: begin
                     if (key_hit) begin
                        state_ff <= S_ACT;
                     end else if (idx_last) begin
                        state_ff <= S_MISS;
                     end else begin
                        idx_ff   <= idx_ff + IDX_W'(1);
                        state_ff <= S_RD;
                     end
                  end
               endcase
            end
            S_ACT: begin
               // key found at idx_ff
               res_hit_ff  <= 1'b1;
               res_slot_ff <= lpc_pkg::SLOT_W'(idx_ff);
               case (kind_ff)
                  lpc_pkg::KIND_DIRTY: begin
                     dirty_ff[idx_ff] <= 1'b1;
                  end
                  lpc_pkg::KIND_PUT: begin
                     if (refs_dec == '0) begin
                        valid_ff[idx_ff] <= 1'b0;
                        dirty_ff[idx_ff] <= 1'b0;
                        if (resident_ff != '0) begin
                           resident_ff <= resident_ff - CNT_W'(1);
                        end
                     end
                  end
                  default: begin
                     hit_cnt_ff <= hit_cnt_ff + lpc_pkg::TOTAL_W'(1);
                  end
               endcase
               state_ff <= S_EMIT;
            end
            S_MISS: begin
               case (kind_ff)
                  lpc_pkg::KIND_LOOKUP: begin
                     miss_cnt_ff <= miss_cnt_ff + lpc_pkg::TOTAL_W'(1);
                     state_ff    <= S_EMIT;
                  end
                  lpc_pkg::KIND_FIND: begin
                     miss_cnt_ff <= miss_cnt_ff + lpc_pkg::TOTAL_W'(1);
                     pos_ff      <= IDX_W'(ENTRIES - 1);
                     step_ff     <= '0;
                     state_ff    <= evict_due ? S_VFIND : S_ALLOC;
                  end
                  default: begin
                     state_ff <= S_EMIT;
                  end
               endcase
            end
            S_VFIND: begin
               // slot at the current tail position
               vslot_ff <= find_slot;
               if (valid_ff[find_slot]) begin
                  state_ff <= S_VCHK;
               end else begin
                  pos_ff  <= pos_ff - IDX_W'(1);
                  step_ff <= step_ff + CNT_W'(1);
                  if (step_ff + CNT_W'(1) == CNT_W'(ENTRIES)) begin
                     res_nv_ff <= 1'b1;
                     state_ff  <= S_EMIT;
                  end
               end
            end
            S_VCHK: begin
               if (rd_refs > REF_BITS'(1)) begin
                  // pinned: rotated to the front, next candidate slides into pos_ff
                  step_ff <= step_ff + CNT_W'(1);
                  if (step_ff + CNT_W'(1) == CNT_W'(ENTRIES)) begin
                     res_nv_ff <= 1'b1;
                     state_ff  <= S_EMIT;
                  end else begin
                     state_ff <= S_VFIND;
                  end
               end else begin
                  if (dirty_ff[vslot_ff]) begin
                     res_wbv_ff <= 1'b1;
                     res_wbi_ff <= rd_ino;
                     res_wbo_ff <= rd_off;
                  end
                  valid_ff[vslot_ff] <= 1'b0;
                  dirty_ff[vslot_ff] <= 1'b0;
                  if (resident_ff != '0) begin
                     resident_ff <= resident_ff - CNT_W'(1);
                  end
                  res_ev_ff <= 1'b1;
                  state_ff  <= S_ALLOC;
               end
            end
            S_ALLOC: begin
               if (free_any) begin
                  valid_ff[free_slot] <= 1'b1;
                  dirty_ff[free_slot] <= 1'b0;
                  resident_ff         <= resident_ff + CNT_W'(1);
                  res_slot_ff         <= lpc_pkg::SLOT_W'(free_slot);
               end else begin
                  res_nv_ff <= 1'b1;
               end
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_hit_ff      <= res_hit_ff;
                  rsp_slot_ff     <= res_slot_ff;
                  rsp_ev_ff       <= res_ev_ff;
                  rsp_nv_ff       <= res_nv_ff;
                  rsp_wbv_ff      <= res_wbv_ff;
                  rsp_wbi_ff      <= res_wbi_ff;
                  rsp_wbo_ff      <= res_wbo_ff;
                  rsp_last_ff     <= 1'b1;
                  rsp_hit_tot_ff  <= hit_cnt_ff;
                  rsp_miss_tot_ff <= miss_cnt_ff;
                  state_ff        <= S_IDLE;
               end
            end
            S_SFIN: begin
               // final sync word, empty when nothing was dirty
               if (out_free) begin
                  rsp_hit_ff      <= 1'b0;
                  rsp_slot_ff     <= '0;
                  rsp_ev_ff       <= 1'b0;
                  rsp_nv_ff       <= 1'b0;
                  rsp_wbv_ff      <= pend_ff;
                  rsp_wbi_ff      <= pend_ff ? pend_ino_ff : '0;
                  rsp_wbo_ff      <= pend_ff ? pend_off_ff : '0;
                  rsp_last_ff     <= 1'b1;
                  rsp_hit_tot_ff  <= hit_cnt_ff;
                  rsp_miss_tot_ff <= miss_cnt_ff;
                  pend_ff         <= 1'b0;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_evicted    = rsp_ev_ff;
   assign rsp_no_victim  = rsp_nv_ff;
   assign rsp_wb_valid   = rsp_wbv_ff;
   assign rsp_wb_inode   = rsp_wbi_ff;
   assign rsp_wb_offset  = rsp_wbo_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_hit_total  = rsp_hit_tot_ff;
   assign rsp_miss_total = rsp_miss_tot_ff;

endmodule

// ===== sim/lru_page_cache_policy_tb.sv =====
// lru_page_cache_policy_tb: self-checking bench for the lru page cache policy block
// depends on lpc_pkg and lru_page_cache_policy; a behavioral page table predicts every word
module lru_page_cache_policy_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  NSLOT       = 16;
   localparam int  CYCLE_LIMIT = 2000000;
   localparam int  DRAIN_WAIT  = 80;
   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;

   typedef struct {
      logic        hit;
      logic [3:0]  slot;
      logic        evicted;
      logic        no_victim;
      logic        wb_valid;
      logic [15:0] wb_inode;
      logic [31:0] wb_offset;
      logic        last;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
   } page_rsp_type;

   typedef struct {
      logic [2:0]  kind;
      logic [15:0] inode;
      logic [31:0] offset;
      logic        every;
      bit          typed;
      logic        hit;
      logic [3:0]  slot;
      logic        evicted;
   } stim_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [4:0]  csr_wr_data = '0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_kind = '0;
   logic [15:0] req_inode_id = '0;
   logic [31:0] req_page_offset = '0;
   logic        req_every_inode = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_hit, rsp_evicted, rsp_no_victim, rsp_wb_valid, rsp_last;
   logic [3:0]  rsp_slot;
   logic [15:0] rsp_wb_inode;
   logic [31:0] rsp_wb_offset, rsp_hit_total, rsp_miss_total;

   lru_page_cache_policy uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_inode_id(req_inode_id), .req_page_offset(req_page_offset),
      .req_every_inode(req_every_inode),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_slot(rsp_slot), .rsp_evicted(rsp_evicted), .rsp_no_victim(rsp_no_victim),
      .rsp_wb_valid(rsp_wb_valid), .rsp_wb_inode(rsp_wb_inode),
      .rsp_wb_offset(rsp_wb_offset), .rsp_last(rsp_last),
      .rsp_hit_total(rsp_hit_total), .rsp_miss_total(rsp_miss_total)
   );

   always #5 clock = ~clock;

   // shadow page table
   logic        pg_valid  [NSLOT];
   logic [15:0] pg_inode  [NSLOT];
   logic [31:0] pg_offset [NSLOT];
   logic        pg_dirty  [NSLOT];
   logic [7:0]  pg_refs   [NSLOT];
   int          pg_rank   [NSLOT];
   int          resident;
   logic [31:0] hit_cnt, miss_cnt;
   logic [4:0]  capacity;

   page_rsp_type pending_rsp[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          idle_on = 1;
   bit          long_hold_req = 0;

   // random key pool so that most operations hit resident pages
   logic [15:0] pool_inode [12];
   logic [31:0] pool_offset[12];

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   function automatic void push_word(input logic hit, input logic [3:0] slot,
                                     input logic ev, input logic nv, input logic wbv,
                                     input logic [15:0] wbi, input logic [31:0] wbo,
                                     input logic last);
      page_rsp_type w;
      w.hit = hit; w.slot = slot; w.evicted = ev; w.no_victim = nv;
      w.wb_valid = wbv; w.wb_inode = wbv ? wbi : '0; w.wb_offset = wbv ? wbo : '0;
      w.last = last; w.hit_total = hit_cnt; w.miss_total = miss_cnt;
      pending_rsp = {pending_rsp, w};
   endfunction

   function automatic int locate_page(input logic [15:0] ino, input logic [31:0] off);
      for (int i = 0; i < NSLOT; i++)
         if (pg_valid[i] && pg_inode[i] == ino && pg_offset[i] == off) return i;
      return -1;
   endfunction

   function automatic void touch(input int s);
      int r;
      r = pg_rank[s];
      for (int i = 0; i < NSLOT; i++)
         if (pg_rank[i] < r) pg_rank[i]++;
      pg_rank[s] = 0;
   endfunction

   function automatic void drop_page(input int s);
      pg_valid[s] = 0;
      pg_dirty[s] = 0;
      if (resident > 0) resident--;
   endfunction

   // walk from the lru tail, pinned pages rotate to the front
   function automatic int choose_victim();
      int order[$];
      for (int rk = NSLOT - 1; rk >= 0; rk--)
         for (int s = 0; s < NSLOT; s++)
            if (pg_valid[s] && pg_rank[s] == rk) order = {order, s};
      foreach (order[i]) begin
         if (pg_refs[order[i]] > 1) touch(order[i]);
         else return order[i];
      end
      return -1;
   endfunction

   function automatic void predict_page_op(input logic [2:0] kind, input logic [15:0] ino,
                                           input logic [31:0] off, input logic every);
      int s, v, n;
      logic ev, wbv;
      logic [15:0] wbi;
      logic [31:0] wbo;
      case (kind)
         lpc_pkg::KIND_LOOKUP, lpc_pkg::KIND_FIND: begin
            s = locate_page(ino, off);
            if (s >= 0) begin
               touch(s);
               hit_cnt++;
               push_word(1, 4'(s), 0, 0, 0, 0, 0, 1);
            end else begin
               miss_cnt++;
               if (kind == lpc_pkg::KIND_LOOKUP) begin
                  push_word(0, 0, 0, 0, 0, 0, 0, 1);
               end else begin
                  ev = 0; wbv = 0; wbi = 0; wbo = 0;
                  v = 0;
                  if ((resident >= capacity || resident >= NSLOT) && resident > 0) begin
                     v = choose_victim();
                     if (v >= 0) begin
                        if (pg_dirty[v]) begin
                           wbv = 1; wbi = pg_inode[v]; wbo = pg_offset[v];
                        end
                        drop_page(v);
                        ev = 1;
                     end
                  end
                  if (v < 0) begin
                     push_word(0, 0, 0, 1, 0, 0, 0, 1);
                  end else begin
                     s = -1;
                     for (int i = 0; i < NSLOT; i++)
                        if (!pg_valid[i] && s < 0) s = i;
                     if (s < 0) begin
                        push_word(0, 0, ev, 1, wbv, wbi, wbo, 1);
                     end else begin
                        pg_valid[s] = 1; pg_inode[s] = ino; pg_offset[s] = off;
                        pg_dirty[s] = 0; pg_refs[s] = 8'd1;
                        touch(s);
                        resident++;
                        push_word(0, 4'(s), ev, 0, wbv, wbi, wbo, 1);
                     end
                  end
               end
            end
         end
         lpc_pkg::KIND_DIRTY: begin
            s = locate_page(ino, off);
            if (s >= 0) begin
               pg_dirty[s] = 1;
               touch(s);
               push_word(1, 4'(s), 0, 0, 0, 0, 0, 1);
            end else push_word(0, 0, 0, 0, 0, 0, 0, 1);
         end
         lpc_pkg::KIND_PUT: begin
            s = locate_page(ino, off);
            if (s >= 0) begin
               pg_refs[s] = pg_refs[s] - 8'd1;
               if (pg_refs[s] == 0) drop_page(s);
               push_word(1, 4'(s), 0, 0, 0, 0, 0, 1);
            end else push_word(0, 0, 0, 0, 0, 0, 0, 1);
         end
         lpc_pkg::KIND_INVAL: begin
            for (int i = 0; i < NSLOT; i++)
               if (pg_valid[i] && pg_inode[i] == ino) drop_page(i);
            push_word(0, 0, 0, 0, 0, 0, 0, 1);
         end
         lpc_pkg::KIND_SYNC: begin
            n = 0;
            for (int i = 0; i < NSLOT; i++)
               if (pg_valid[i] && pg_dirty[i] && (every || pg_inode[i] == ino)) begin
                  pg_dirty[i] = 0;
                  push_word(0, 0, 0, 0, 1, pg_inode[i], pg_offset[i], 0);
                  n++;
               end
            if (n == 0) push_word(0, 0, 0, 0, 0, 0, 0, 1);
            else pending_rsp[$].last = 1;
         end
         default: push_word(0, 0, 0, 0, 0, 0, 0, 1);
      endcase
   endfunction

   // offer one word after a random gap, return once it is taken
   task automatic send_word(input logic [2:0] kind, input logic [15:0] ino,
                            input logic [31:0] off, input logic every, input bit no_gap);
      int gap;
      gap = (idle_on && !no_gap) ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1;
      req_kind        <= kind;
      req_inode_id    <= ino;
      req_page_offset <= off;
      req_every_inode <= every;
      do @(posedge clock); while (req_stall);
      predict_page_op(kind, ino, off, every);
   endtask

   // capacity is only changed with the block idle
   task automatic set_capacity(input logic [4:0] value);
      req_valid <= 0;
      wait (pending_rsp.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
      capacity = value;
   endtask

   task automatic send_random(input bit no_gap);
      int pick, k;
      logic [2:0]  kind;
      logic [15:0] ino;
      logic [31:0] off;
      pick = $urandom_range(0, 99);
      if (pick < 35) kind = lpc_pkg::KIND_FIND;
      else if (pick < 50) kind = lpc_pkg::KIND_LOOKUP;
      else if (pick < 70) kind = lpc_pkg::KIND_DIRTY;
      else if (pick < 85) kind = lpc_pkg::KIND_PUT;
      else if (pick < 90) kind = lpc_pkg::KIND_INVAL;
      else if (pick < 97) kind = lpc_pkg::KIND_SYNC;
      else kind = (pick == 97) ? KIND_SPARE6 : KIND_SPARE7;
      k = $urandom_range(0, 11);
      if ($urandom_range(0, 4) == 0) begin
         ino = 16'($urandom);
         off = $urandom;
      end else begin
         ino = pool_inode[k];
         off = pool_offset[k];
      end
      send_word(kind, ino, off, 1'($urandom), no_gap);
   endtask

   // result side: random stall per word plus one long hold-off on request
   initial begin : rsp_side
      int stall_left, long_left;
      logic next_stall;
      page_rsp_type w;
      stall_left = 0;
      long_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && !rsp_stall) begin
               if (pending_rsp.size() == 0) begin
                  report("unexpected word, hit_total", rsp_hit_total, 0);
               end else begin
                  w = pending_rsp.pop_front();
                  if (rsp_hit !== w.hit) report("hit", rsp_hit, w.hit);
                  if (rsp_slot !== w.slot) report("slot", rsp_slot, w.slot);
                  if (rsp_evicted !== w.evicted) report("evicted", rsp_evicted, w.evicted);
                  if (rsp_no_victim !== w.no_victim)
                     report("no_victim", rsp_no_victim, w.no_victim);
                  if (rsp_wb_valid !== w.wb_valid) report("wb_valid", rsp_wb_valid, w.wb_valid);
                  if (rsp_wb_inode !== w.wb_inode) report("wb_inode", rsp_wb_inode, w.wb_inode);
                  if (rsp_wb_offset !== w.wb_offset)
                     report("wb_offset", rsp_wb_offset, w.wb_offset);
                  if (rsp_last !== w.last) report("last", rsp_last, w.last);
                  if (rsp_hit_total !== w.hit_total)
                     report("hit_total", rsp_hit_total, w.hit_total);
                  if (rsp_miss_total !== w.miss_total)
                     report("miss_total", rsp_miss_total, w.miss_total);
               end
               stall_left = idle_on ? $urandom_range(0, 12) : 0;
            end
            if (long_hold_req) begin
               long_hold_req = 0;
               long_left = 400;
            end
            next_stall = 0;
            if (long_left > 0) begin
               long_left--;
               next_stall = 1;
            end else if (stall_left > 0) begin
               stall_left--;
               next_stall = 1;
            end
            rsp_stall <= next_stall;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   stim_row_type directed[23] = '{
      '{lpc_pkg::KIND_LOOKUP, 16'h0000, 32'h0000_0000, 0, 1, 0, 4'd0, 0},
      '{lpc_pkg::KIND_FIND,   16'h0000, 32'h0000_0000, 0, 1, 0, 4'd0, 0},
      '{lpc_pkg::KIND_FIND,   16'h0000, 32'h0000_0000, 0, 1, 1, 4'd0, 0},
      '{lpc_pkg::KIND_FIND,   16'hFFFF, 32'hFFFF_FFFF, 1, 1, 0, 4'd1, 0},
      '{lpc_pkg::KIND_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 0, 1, 1, 4'd1, 0},
      '{lpc_pkg::KIND_DIRTY,  16'h0000, 32'h0000_0000, 0, 1, 1, 4'd0, 0},
      '{lpc_pkg::KIND_DIRTY,  16'h0001, 32'h0000_0001, 0, 1, 0, 4'd0, 0},
      '{lpc_pkg::KIND_SYNC,   16'h1234, 32'h0000_0000, 1, 0, 0, 4'd0, 0},
      '{lpc_pkg::KIND_DIRTY,  16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0, 4'd0, 0},
      '{lpc_pkg::KIND_DIRTY,  16'h0000, 32'h0000_0000, 0, 0, 0, 4'd0, 0},
      '{lpc_pkg::KIND_SYNC,   16'h0000, 32'h0000_0000, 0, 0, 0, 4'd0, 0},
      '{lpc_pkg::KIND_SYNC,   16'h0000, 32'hFFFF_FFFF, 1, 0, 0, 4'd0, 0},
      '{lpc_pkg::KIND_SYNC,   16'hFFFF, 32'h0000_0000, 1, 1, 0, 4'd0, 0},
      '{lpc_pkg::KIND_FIND,   16'h00A5, 32'h5A5A_A5A5, 0, 0, 0, 4'd0, 0},
      '{lpc_pkg::KIND_PUT,    16'h0000, 32'h0000_0000, 0, 1, 1, 4'd0, 0},
      '{lpc_pkg::KIND_PUT,    16'h0000, 32'h0000_0000, 0, 1, 0, 4'd0, 0},
      '{lpc_pkg::KIND_FIND,   16'h0000, 32'h8000_0000, 0, 0, 0, 4'd0, 0},
      '{lpc_pkg::KIND_INVAL,  16'hFFFF, 32'h0000_0000, 0, 1, 0, 4'd0, 0},
      '{lpc_pkg::KIND_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 0, 1, 0, 4'd0, 0},
      '{KIND_SPARE6,          16'hFFFF, 32'hFFFF_FFFF, 1, 1, 0, 4'd0, 0},
      '{KIND_SPARE7,          16'h0000, 32'h0000_0000, 0, 1, 0, 4'd0, 0},
      '{lpc_pkg::KIND_INVAL,  16'h0000, 32'h0000_0000, 0, 0, 0, 4'd0, 0},
      '{lpc_pkg::KIND_INVAL,  16'h00A5, 32'h0000_0000, 0, 0, 0, 4'd0, 0}
   };

   logic [4:0] cap_steps[8] = '{5'd1, 5'd16, 5'd4, 5'd0, 5'd31, 5'd8, 5'd2, 5'd12};

   initial begin : stimulus
      page_rsp_type w;
      for (int i = 0; i < NSLOT; i++) begin
         pg_valid[i] = 0; pg_dirty[i] = 0; pg_inode[i] = 0;
         pg_offset[i] = 0; pg_refs[i] = 0; pg_rank[i] = i;
      end
      resident = 0; hit_cnt = 0; miss_cnt = 0;
      capacity = lpc_pkg::CAP_RESET;
      for (int k = 0; k < 12; k++) begin
         pool_inode[k]  = (k < 2) ? 16'(k * 16'hFFFF) : 16'($urandom_range(1, 4));
         pool_offset[k] = (k == 0) ? 32'hFFFF_FFFF : (k == 1) ? 32'h0 : $urandom;
      end
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed table; typed rows override hit, slot and evicted of the last predicted word
      foreach (directed[i]) begin
         send_word(directed[i].kind, directed[i].inode, directed[i].offset,
                   directed[i].every, 0);
         if (directed[i].typed) begin
            w = pending_rsp[$];
            w.hit = directed[i].hit;
            w.slot = directed[i].slot;
            w.evicted = directed[i].evicted;
            pending_rsp[$] = w;
         end
      end

      // random phases across capacity settings
      foreach (cap_steps[p]) begin
         set_capacity(cap_steps[p]);
         idle_on = (p != 5);
         if (p == 2) begin
            // hold the result side while offering words back to back
            long_hold_req = 1;
            repeat (30) send_random(1);
            req_valid <= 0;
            wait (pending_rsp.size() == 0);
            @(posedge clock);
         end
         repeat (35) send_random(0);
      end
      req_valid <= 0;

      wait (pending_rsp.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== lru_page_cache_policy.f =====
rtl/lpc_pkg.sv
rtl/lpc_ram.sv
rtl/lpc_lru.sv
rtl/lru_page_cache_policy.sv
sim/lru_page_cache_policy_tb.sv
